@@ hw/rtl/quaternion_arithmetic_unit_top_macros.svh @@
// Assertion macros for the quaternion unit
`ifndef QUATERNION_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define QUATERNION_ARITHMETIC_UNIT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define QAU_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define QAU_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define QAU_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define QAU_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

@@ hw/rtl/qau_pkg.sv @@
`default_nettype none
package qau_pkg;
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_MUL = 3'd1,
        OP_SCALE = 3'd2,
        OP_NORM = 3'd3,
        OP_INV = 3'd4,
        OP_ANG = 3'd5
    } op_t;

    // Norm sequencer states
    typedef enum logic [2:0] {N_IDLE, N_SQ, N_SQRT, N_DIV, N_DONE} nst_t;

    localparam int unsigned QFRAC = 16;
    localparam int unsigned SQRT_STEPS = 33;
    localparam int unsigned DIV_STEPS = 48;

    typedef struct packed {
        logic [2:0] req_type;
        logic signed [31:0] a_w;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
    } req_t;

    typedef struct packed {
        logic signed [31:0] r_w;
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic zero_norm_error;
        logic saturated;
    } rsp_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic is_norm;
        req_t req;
    } cls_t;

    // floor(x*y / 2^16) on the exact product
    function automatic logic signed [47:0] qmul(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
        logic signed [63:0] p;
        begin
            p = x * y;
            qmul = p[63:16];
        end
    endfunction

    // Clip to 32 bits signed
    function automatic logic signed [32:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sh7FFFFFFF)
                sat32 = {1'b1, 32'h7FFFFFFF};
            else if (v < -64'sh80000000)
                sat32 = {1'b1, 32'h80000000};
            else
                sat32 = {1'b0, v[31:0]};
        end
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/quaternion_arithmetic_unit_top.sv @@
// Add, multiply, scale and angular update pass through the queue, product stage, sum stage
// and output register; one per cycle while neither out_stall nor a running norm holds them.
// Throughput is set by the queue pop feeding the pipe, which stalls as a whole.
// Normalise and inverse run through the queue, 4 square, 33 root, 4 x 48 divide and done steps,
// once earlier requests have left the pipe; no request is taken while one is running.
// Reset: rst_n asynchronous active low clears the queue, pipe valids and norm sequencer.
`default_nettype none
`include "quaternion_arithmetic_unit_top_macros.svh"
module quaternion_arithmetic_unit_top #(
    parameter int QUEUE_LOG2 = 2
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_stall,
    input wire qau_pkg::req_t in_data,
    output logic out_valid,
    input wire logic out_stall,
    output qau_pkg::rsp_t out_data
);
    logic q_valid, q_pop;
    qau_pkg::cls_t q_data;

    qau_front #(.DEPTH_LOG2(QUEUE_LOG2)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
    );

    qau_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    `QAU_ASSERT_CLK(a_pop_valid, clk, rst_n, q_pop |-> q_valid, "pop from empty queue")
    `QAU_ASSERT_NEVER(a_err_sat, clk, rst_n, out_valid && out_data.zero_norm_error && out_data.saturated, "both flags set")
endmodule
`default_nettype wire

@@ hw/rtl/qau_front.sv @@
`default_nettype none
// Accept requests, classify them and push into the queue
module qau_front #(
    parameter int DEPTH_LOG2 = 2
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_stall,
    input wire qau_pkg::req_t in_data,
    output logic q_valid,
    input wire logic q_pop,
    output qau_pkg::cls_t q_data
);
    localparam int DEPTH = 1 << DEPTH_LOG2;
    qau_pkg::cls_t mem [DEPTH];
    logic [DEPTH_LOG2:0] wp_reg, wp_next, rp_reg, rp_next;
    logic full, empty, push;

    assign full = (wp_reg[DEPTH_LOG2] != rp_reg[DEPTH_LOG2]) &&
                  (wp_reg[DEPTH_LOG2-1:0] == rp_reg[DEPTH_LOG2-1:0]);
    assign empty = (wp_reg == rp_reg);
    assign in_stall = full;
    assign push = in_valid && !full;
    assign q_valid = !empty;
    assign q_data = mem[rp_reg[DEPTH_LOG2-1:0]];
    assign wp_next = wp_reg + (DEPTH_LOG2+1)'(push);
    assign rp_next = rp_reg + (DEPTH_LOG2+1)'(q_pop && !empty);

    // Store classified item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg[DEPTH_LOG2-1:0]].req <= in_data;
            mem[wp_reg[DEPTH_LOG2-1:0]].is_norm <=
                (in_data.req_type == qau_pkg::OP_NORM) || (in_data.req_type == qau_pkg::OP_INV);
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/qau_norm.sv @@
`default_nettype none
// Iterative norm: square sum, bit-serial square root, four restoring divides
module qau_norm (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire qau_pkg::req_t req,
    output logic busy,
    output logic done,
    output qau_pkg::rsp_t rsp
);
    qau_pkg::nst_t st_reg, st_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] k_reg, k_next;
    logic [65:0] s_reg, s_next;
    logic [32:0] root_reg, root_next;
    logic [66:0] rem_reg, rem_next;
    logic [47:0] dq_reg, dq_next;
    logic [33:0] drem_reg, drem_next;
    logic [31:0] res_reg [4];
    logic inv_reg, inv_next;
    qau_pkg::req_t q_reg;
    logic [31:0] mag [4];
    logic sgn [4];
    logic [66:0] trial;
    logic [34:0] dtrial;

    always_comb
    begin
        mag[0] = q_reg.a_w[31] ? 32'(-q_reg.a_w) : q_reg.a_w;
        mag[1] = q_reg.a_x[31] ? 32'(-q_reg.a_x) : q_reg.a_x;
        mag[2] = q_reg.a_y[31] ? 32'(-q_reg.a_y) : q_reg.a_y;
        mag[3] = q_reg.a_z[31] ? 32'(-q_reg.a_z) : q_reg.a_z;
        sgn[0] = q_reg.a_w[31];
        sgn[1] = q_reg.a_x[31];
        sgn[2] = q_reg.a_y[31];
        sgn[3] = q_reg.a_z[31];
    end

    assign trial = {rem_reg[64:0], s_reg[65:64]} - {32'h0, root_reg, 2'b01};
    assign dtrial = {drem_reg, dq_reg[47]} - {2'b0, root_reg};

    // Next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            qau_pkg::N_IDLE: if (start) st_next = qau_pkg::N_SQ;
            qau_pkg::N_SQ: if (k_reg == 2'd3) st_next = qau_pkg::N_SQRT;
            qau_pkg::N_SQRT: if (cnt_reg == 6'(qau_pkg::SQRT_STEPS - 1))
                st_next = qau_pkg::N_DIV;
            qau_pkg::N_DIV: if (cnt_reg == 6'(qau_pkg::DIV_STEPS - 1) && k_reg == 2'd3)
                st_next = qau_pkg::N_DONE;
            qau_pkg::N_DONE: st_next = qau_pkg::N_IDLE;
            default: st_next = qau_pkg::N_IDLE;
        endcase
    end

    // Datapath steps
    always_comb
    begin
        cnt_next = cnt_reg;
        k_next = k_reg;
        s_next = s_reg;
        root_next = root_reg;
        rem_next = rem_reg;
        dq_next = dq_reg;
        drem_next = drem_reg;
        inv_next = inv_reg;
        case (st_reg)
            qau_pkg::N_IDLE:
            begin
                k_next = '0;
                s_next = '0;
                inv_next = (req.req_type == qau_pkg::OP_INV);
            end
            qau_pkg::N_SQ:
            begin
                s_next = s_reg + 66'(mag[k_reg] * mag[k_reg]);
                k_next = k_reg + 2'd1;
                cnt_next = '0;
                root_next = '0;
                rem_next = '0;
            end
            qau_pkg::N_SQRT:
            begin
                // one result bit per step, two radicand bits consumed
                if (!trial[66])
                begin
                    rem_next = trial;
                    root_next = {root_reg[31:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[64:0], s_reg[65:64]};
                    root_next = {root_reg[31:0], 1'b0};
                end
                s_next = s_reg << 2;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(qau_pkg::SQRT_STEPS - 1))
                begin
                    cnt_next = '0;
                    k_next = '0;
                    dq_next = {mag[0], 16'h0};
                    drem_next = '0;
                end
            end
            qau_pkg::N_DIV:
            begin
                if (!dtrial[34])
                begin
                    drem_next = dtrial[33:0];
                    dq_next = {dq_reg[46:0], 1'b1};
                end
                else
                begin
                    drem_next = {drem_reg[32:0], dq_reg[47]};
                    dq_next = {dq_reg[46:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(qau_pkg::DIV_STEPS - 1))
                begin
                    cnt_next = '0;
                    k_next = k_reg + 2'd1;
                    drem_next = '0;
                    dq_next = {mag[2'(k_reg + 2'd1)], 16'h0};
                end
            end
            default: ;
        endcase
    end

    // Capture the request, divider lane results and datapath registers
    always_ff @(posedge clk)
    begin
        if (st_reg == qau_pkg::N_IDLE && start)
            q_reg <= req;
        if (st_reg == qau_pkg::N_DIV && cnt_reg == 6'(qau_pkg::DIV_STEPS - 1))
            res_reg[k_reg] <= 32'({dq_reg[46:0], !dtrial[34]});
        s_reg <= s_next;
        root_reg <= root_next;
        rem_reg <= rem_next;
        dq_reg <= dq_next;
        drem_reg <= drem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= qau_pkg::N_IDLE;
            cnt_reg <= '0;
            k_reg <= '0;
            inv_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            cnt_reg <= cnt_next;
            k_reg <= k_next;
            inv_reg <= inv_next;
        end
    end

    // Outputs
    always_comb
    begin
        logic [31:0] v [4];
        logic zero;
        zero = (root_reg == '0);
        busy = (st_reg != qau_pkg::N_IDLE);
        done = (st_reg == qau_pkg::N_DONE);
        for (int i = 0; i < 4; i++)
        begin
            v[i] = sgn[i] ? 32'(-res_reg[i]) : res_reg[i];
            if (inv_reg && i != 0)
                v[i] = 32'(-v[i]);
            if (zero)
                v[i] = '0;
        end
        rsp.r_w = v[0];
        rsp.r_x = v[1];
        rsp.r_y = v[2];
        rsp.r_z = v[3];
        rsp.zero_norm_error = zero;
        rsp.saturated = 1'b0;
    end
endmodule
`default_nettype wire

@@ hw/rtl/qau_back.sv @@
`default_nettype none
// Execute: three-stage arithmetic pipe plus iterative norm unit
module qau_back (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic q_valid,
    output logic q_pop,
    input wire qau_pkg::cls_t q_data,
    output logic out_valid,
    input wire logic out_stall,
    output qau_pkg::rsp_t out_data
);
    logic v1_reg, v2_reg, v3_reg;
    qau_pkg::req_t r1_reg, r2_reg;
    logic signed [47:0] t_reg [16];
    logic signed [31:0] p_reg [4];
    logic ps_reg;
    qau_pkg::rsp_t o_reg;
    logic adv;
    logic nbusy, ndone, nstart;
    qau_pkg::rsp_t nrsp;
    logic signed [31:0] a [4];
    logic signed [31:0] b [4];
    logic signed [31:0] om [4];
    logic signed [31:0] a2 [4];

    // Pipe advances when the last register is free; norm requests wait for the pipe to drain
    assign adv = !v3_reg || !out_stall;
    assign nstart = q_valid && q_data.is_norm && !nbusy && !v1_reg && !v2_reg && adv;
    assign q_pop = q_valid && adv && (q_data.is_norm ? nstart : !nbusy);

    qau_norm u_norm (
        .clk(clk), .rst_n(rst_n), .start(nstart), .req(q_data.req),
        .busy(nbusy), .done(ndone), .rsp(nrsp)
    );

    always_comb
    begin
        a[0] = q_data.req.a_w; a[1] = q_data.req.a_x;
        a[2] = q_data.req.a_y; a[3] = q_data.req.a_z;
        b[0] = q_data.req.b_w; b[1] = q_data.req.b_x;
        b[2] = q_data.req.b_y; b[3] = q_data.req.b_z;
        om[0] = (q_data.req.req_type == qau_pkg::OP_ANG) ? 32'sd0 : b[0];
        om[1] = b[1]; om[2] = b[2]; om[3] = b[3];
        a2[0] = r2_reg.a_w; a2[1] = r2_reg.a_x; a2[2] = r2_reg.a_y; a2[3] = r2_reg.a_z;
    end

    // Stage 1: sixteen truncated products; scale uses the first column
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg <= q_data.req;
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    t_reg[i*4+j] <= qau_pkg::qmul(a[i], om[j]);
        end
    end

    // Stage 2: sums and saturation
    always_ff @(posedge clk)
    begin
        logic signed [63:0] s [4];
        logic signed [32:0] c [4];
        logic f;
        s[0] = 64'(t_reg[0]) - 64'(t_reg[5]) - 64'(t_reg[10]) - 64'(t_reg[15]);
        s[1] = 64'(t_reg[1]) + 64'(t_reg[4]) + 64'(t_reg[11]) - 64'(t_reg[14]);
        s[2] = 64'(t_reg[2]) + 64'(t_reg[8]) + 64'(t_reg[13]) - 64'(t_reg[7]);
        s[3] = 64'(t_reg[3]) + 64'(t_reg[12]) + 64'(t_reg[6]) - 64'(t_reg[9]);
        case (r1_reg.req_type)
            qau_pkg::OP_ADD:
            begin
                s[0] = 64'(r1_reg.a_w) + 64'(r1_reg.b_w);
                s[1] = 64'(r1_reg.a_x) + 64'(r1_reg.b_x);
                s[2] = 64'(r1_reg.a_y) + 64'(r1_reg.b_y);
                s[3] = 64'(r1_reg.a_z) + 64'(r1_reg.b_z);
            end
            qau_pkg::OP_SCALE:
                for (int i = 0; i < 4; i++)
                    s[i] = 64'(t_reg[i*4]);
            default: ;
        endcase
        f = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            c[i] = qau_pkg::sat32(s[i]);
            f = f | c[i][32];
        end
        if (adv)
        begin
            r2_reg <= r1_reg;
            for (int i = 0; i < 4; i++)
                p_reg[i] <= c[i][31:0];
            ps_reg <= f;
        end
    end

    // Stage 3: angular update tail and result select
    always_ff @(posedge clk)
    begin
        logic signed [63:0] m;
        logic signed [63:0] u;
        logic signed [32:0] c;
        logic f;
        logic [31:0] rr [4];
        f = ps_reg;
        for (int i = 0; i < 4; i++)
        begin
            m = p_reg[i] * r2_reg.b_w;
            u = 64'(a2[i]) + (m >>> 17);
            c = qau_pkg::sat32(u);
            rr[i] = p_reg[i];
            if (r2_reg.req_type == qau_pkg::OP_ANG)
            begin
                rr[i] = c[31:0];
                f = f | c[32];
            end
        end
        if (!(r2_reg.req_type == qau_pkg::OP_ADD || r2_reg.req_type == qau_pkg::OP_MUL ||
              r2_reg.req_type == qau_pkg::OP_SCALE || r2_reg.req_type == qau_pkg::OP_ANG))
        begin
            for (int i = 0; i < 4; i++)
                rr[i] = '0;
            f = 1'b0;
        end
        if (ndone)
            o_reg <= nrsp;
        else if (adv)
        begin
            o_reg.r_w <= rr[0];
            o_reg.r_x <= rr[1];
            o_reg.r_y <= rr[2];
            o_reg.r_z <= rr[3];
            o_reg.zero_norm_error <= 1'b0;
            o_reg.saturated <= f;
        end
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ndone)
                v3_reg <= 1'b1;
            else if (adv)
            begin
                v1_reg <= q_valid && q_pop && !q_data.is_norm;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
        end
    end

    assign out_valid = v3_reg;
    assign out_data = o_reg;
endmodule
`default_nettype wire
